/* sv/multi_pattern_censoring_filter_top_defines.svh */
// assertion macros shared by the filter top level
`ifndef MULTI_PATTERN_CENSORING_FILTER_TOP_DEFINES_SVH
`define MULTI_PATTERN_CENSORING_FILTER_TOP_DEFINES_SVH

// same-cycle implication on the block clock
`define MPCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mpcf same-cycle check failed");

// next-cycle implication on the block clock
`define MPCF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mpcf next-cycle check failed");

`endif

/* sv/mpcf_pkg.sv */
package mpcf_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int ALPHABET    = 26;
    localparam int MAX_TEXT    = 4096;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int SYM_W       = 5;
    localparam int POS_W       = 12;
    localparam int DEPTH_W     = $clog2(MAX_TEXT + 1);
    localparam int TEXT_AW     = $clog2(MAX_TEXT);
    localparam int SSTACK_D    = MAX_TEXT + 1;
    localparam int SSTACK_AW   = $clog2(SSTACK_D);
    localparam int CHILD_D     = MAX_NODES * ALPHABET;
    localparam int CHILD_AW    = $clog2(CHILD_D);
    localparam int STATUS_W    = 3;
    localparam int REMOVED_W   = 10;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_BUILD   = 2'd1,
        OP_TEXT    = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NODE_FULL  = 3'd1,
        ST_TEXT_FULL  = 3'd2,
        ST_POS_BEYOND = 3'd3,
        ST_WRONG      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS,
        S_TXT_NXT,
        S_TXT_ML,
        S_TXT_TOP,
        S_READ,
        S_B_ROOT_RD,
        S_B_ROOT_WR,
        S_B_POP,
        S_B_FAIL,
        S_B_ROW,
        S_B_RD,
        S_B_WR,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] target;
    } child_t;

    // letters past the alphabet fold onto the last letter
    function automatic logic [SYM_W-1:0] clamp_sym(input logic [SYM_W-1:0] s);
        return (int'(s) >= ALPHABET) ? SYM_W'(ALPHABET - 1) : s;
    endfunction

    // flat goto table index of (node, letter)
    function automatic logic [CHILD_AW-1:0] child_index(input logic [NODE_W-1:0] row,
                                                         input logic [SYM_W-1:0] c);
        return CHILD_AW'(CHILD_AW'(row) * CHILD_AW'(ALPHABET) + CHILD_AW'(c));
    endfunction

endpackage

/* sv/mpcf_ram.sv */
module mpcf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/multi_pattern_censoring_filter_top.sv */
// Aho-Corasick censoring filter. After reset the block clears its goto table, one
// entry a cycle, and takes no request until then. Each request gives one response:
// a pattern symbol passes through S_INS and a kept-text read through S_READ. A text
// symbol passes through S_TXT_NXT and S_TXT_ML, and also S_TXT_TOP when a match is
// removed and leaves text behind, because the goto table, the match-length store
// and the state stack are each read in turn through their registered-read memories.
// Wrong-phase and text-store-full requests go straight to S_DONE; a pattern symbol
// dropped on a full node store passes through S_INS. The build request walks the
// trie breadth first through each letter of the root and of every other node,
// taking each node off the queue through S_B_POP, S_B_FAIL and S_B_ROW. The
// response then waits in the response register while the next request is let in.
`include "multi_pattern_censoring_filter_top_defines.svh"

module multi_pattern_censoring_filter_top
    import mpcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // symbol[4:0], position[16:5], zero fill
    input  logic        s_tlast,   // pattern_end
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[2:0], kept_length[15:3],
                                   // removed_count[25:16], read_symbol[30:26]
);

    fsm_t                  state_reg, state_next;
    logic [CHILD_AW-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]      ncount_reg, ncount_next;
    logic [NODE_W-1:0]     cursor_reg, cursor_next;
    logic [NODE_W-1:0]     cdepth_reg, cdepth_next;
    logic                  built_reg, built_next;
    logic [DEPTH_W-1:0]    sdepth_reg, sdepth_next;
    logic [NODE_W-1:0]     top_reg, top_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic                  last_reg, last_next;
    logic [NODE_W-1:0]     head_reg, head_next;
    logic [NODE_W-1:0]     tail_reg, tail_next;
    logic [SYM_W-1:0]      c_reg, c_next;
    logic [NODE_W-1:0]     u_reg, u_next;
    logic [NODE_W-1:0]     f_reg, f_next;
    status_t               status_reg, status_next;
    logic [REMOVED_W-1:0]  removed_reg, removed_next;
    logic [SYM_W-1:0]      rsym_reg, rsym_next;
    logic                  mvalid_reg, mvalid_next;
    logic [31:0]           mdata_reg, mdata_next;

    // memory controls
    logic                  ch_we;
    logic [CHILD_AW-1:0]   ch_waddr, ch_raddr_a, ch_raddr_b;
    child_t                ch_wdata, ch_rdata_a, ch_rdata_b;
    logic                  fl_we;
    logic [NODE_W-1:0]     fl_waddr, fl_wdata, fl_raddr, fl_rdata;
    logic                  q_we;
    logic [NODE_W-1:0]     q_waddr, q_wdata, q_raddr, q_rdata;
    logic                  ml_we;
    logic [NODE_W-1:0]     ml_waddr, ml_wdata, ml_raddr, ml_rdata;
    logic                  ss_we;
    logic [SSTACK_AW-1:0]  ss_waddr, ss_raddr;
    logic [NODE_W-1:0]     ss_wdata, ss_rdata;
    logic                  tx_we;
    logic [TEXT_AW-1:0]    tx_waddr, tx_raddr;
    logic [SYM_W-1:0]      tx_wdata, tx_rdata;

    logic                  s_acc;
    logic [SYM_W-1:0]      in_sym;
    logic [POS_W-1:0]      in_pos;
    op_t                   in_op;
    logic [NODE_W-1:0]     new_cdepth;
    logic [DEPTH_W-1:0]    m_len, left_depth;

    // goto table, two identical copies for two read ports
    mpcf_ram #(.DEPTH(CHILD_D), .WIDTH($bits(child_t))) u_child_a (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr_a), .rdata(ch_rdata_a)
    );
    mpcf_ram #(.DEPTH(CHILD_D), .WIDTH($bits(child_t))) u_child_b (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr_b), .rdata(ch_rdata_b)
    );
    mpcf_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
        .aclk(aclk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );
    mpcf_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    mpcf_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_mlen (
        .aclk(aclk), .we(ml_we), .waddr(ml_waddr), .wdata(ml_wdata),
        .raddr(ml_raddr), .rdata(ml_rdata)
    );
    mpcf_ram #(.DEPTH(SSTACK_D), .WIDTH(NODE_W)) u_sstack (
        .aclk(aclk), .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata),
        .raddr(ss_raddr), .rdata(ss_rdata)
    );
    mpcf_ram #(.DEPTH(MAX_TEXT), .WIDTH(SYM_W)) u_text (
        .aclk(aclk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
        .raddr(tx_raddr), .rdata(tx_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_sym   = clamp_sym(s_tdata[4:0]);
    assign in_pos   = s_tdata[16:5];
    assign in_op    = op_t'(s_tuser);
    assign new_cdepth = cdepth_reg + NODE_W'(1);
    assign m_len    = (DEPTH_W'(ml_rdata) > sdepth_reg) ? sdepth_reg : DEPTH_W'(ml_rdata);
    assign left_depth = sdepth_reg - m_len;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // state register and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            ncount_reg <= CNT_W'(1);
            cursor_reg <= '0;
            cdepth_reg <= '0;
            built_reg  <= 1'b0;
            sdepth_reg <= '0;
            top_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ncount_reg <= ncount_next;
            cursor_reg <= cursor_next;
            cdepth_reg <= cdepth_next;
            built_reg  <= built_next;
            sdepth_reg <= sdepth_next;
            top_reg    <= top_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        c_reg       <= c_next;
        u_reg       <= u_next;
        f_reg       <= f_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        rsym_reg    <= rsym_next;
        mdata_reg   <= mdata_next;
    end

    // sequencer: next state, memory accesses and response
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        ncount_next  = ncount_reg;
        cursor_next  = cursor_reg;
        cdepth_next  = cdepth_reg;
        built_next   = built_reg;
        sdepth_next  = sdepth_reg;
        top_next     = top_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        c_next       = c_reg;
        u_next       = u_reg;
        f_next       = f_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        rsym_next    = rsym_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;

        ch_we      = 1'b0;
        ch_waddr   = '0;
        ch_wdata   = '0;
        ch_raddr_a = '0;
        ch_raddr_b = '0;
        fl_we      = 1'b0;
        fl_waddr   = '0;
        fl_wdata   = '0;
        fl_raddr   = '0;
        q_we       = 1'b0;
        q_waddr    = tail_reg;
        q_wdata    = '0;
        q_raddr    = head_reg;
        ml_we      = 1'b0;
        ml_waddr   = '0;
        ml_wdata   = '0;
        ml_raddr   = '0;
        ss_we      = 1'b0;
        ss_waddr   = '0;
        ss_wdata   = '0;
        ss_raddr   = '0;
        tx_we      = 1'b0;
        tx_waddr   = '0;
        tx_wdata   = '0;
        tx_raddr   = '0;

        unique case (state_reg)
            // goto table clearing pass after reset, root match length zero
            S_CLEAR: begin
                ch_we    = 1'b1;
                ch_waddr = clr_reg;
                ml_we    = (clr_reg == '0);
                if (clr_reg == CHILD_AW'(CHILD_D - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + CHILD_AW'(1);
                end
            end

            // take a request and, where it needs one, start its first memory read
            S_IDLE: begin
                if (s_acc) begin
                    sym_next     = in_sym;
                    last_next    = s_tlast;
                    status_next  = ST_OK;
                    removed_next = '0;
                    rsym_next    = '0;
                    unique case (in_op)
                        OP_PATTERN: begin
                            if (built_reg) begin
                                status_next = ST_WRONG;
                                state_next  = S_DONE;
                            end else begin
                                ch_raddr_a = child_index(cursor_reg, in_sym);
                                state_next = S_INS;
                            end
                        end
                        OP_BUILD: begin
                            if (built_reg) begin
                                status_next = ST_WRONG;
                                state_next  = S_DONE;
                            end else begin
                                c_next     = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = S_B_ROOT_RD;
                            end
                        end
                        OP_TEXT: begin
                            if (!built_reg) begin
                                status_next = ST_WRONG;
                                state_next  = S_DONE;
                            end else if (sdepth_reg >= DEPTH_W'(MAX_TEXT)) begin
                                status_next = ST_TEXT_FULL;
                                state_next  = S_DONE;
                            end else begin
                                ch_raddr_a = child_index(top_reg, in_sym);
                                state_next = S_TXT_NXT;
                            end
                        end
                        OP_READ: begin
                            if (DEPTH_W'(in_pos) >= sdepth_reg) begin
                                status_next = ST_POS_BEYOND;
                                state_next  = S_DONE;
                            end else begin
                                tx_raddr   = TEXT_AW'(in_pos);
                                state_next = S_READ;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // trie insert: follow or create the child
            S_INS: begin
                state_next = S_DONE;
                if (!ch_rdata_a.valid) begin
                    if (ncount_reg >= CNT_W'(MAX_NODES)) begin
                        status_next = ST_NODE_FULL;
                        if (last_reg) begin
                            cursor_next = '0;
                            cdepth_next = '0;
                        end
                    end else begin
                        ch_we           = 1'b1;
                        ch_waddr        = child_index(cursor_reg, sym_reg);
                        ch_wdata.valid  = 1'b1;
                        ch_wdata.target = NODE_W'(ncount_reg);
                        ml_we           = 1'b1;
                        ml_waddr        = NODE_W'(ncount_reg);
                        ml_wdata        = last_reg ? new_cdepth : '0;
                        ncount_next     = ncount_reg + CNT_W'(1);
                        cursor_next     = last_reg ? '0 : NODE_W'(ncount_reg);
                        cdepth_next     = last_reg ? '0 : new_cdepth;
                    end
                end else begin
                    if (last_reg) begin
                        ml_we    = 1'b1;
                        ml_waddr = ch_rdata_a.target;
                        ml_wdata = new_cdepth;
                    end
                    cursor_next = last_reg ? '0 : ch_rdata_a.target;
                    cdepth_next = last_reg ? '0 : new_cdepth;
                end
            end

            // text symbol: push symbol and next state, fetch its match length
            S_TXT_NXT: begin
                tx_we       = 1'b1;
                tx_waddr    = TEXT_AW'(sdepth_reg);
                tx_wdata    = sym_reg;
                ss_we       = 1'b1;
                ss_waddr    = SSTACK_AW'(sdepth_reg + DEPTH_W'(1));
                ss_wdata    = ch_rdata_a.target;
                ml_raddr    = ch_rdata_a.target;
                sdepth_next = sdepth_reg + DEPTH_W'(1);
                top_next    = ch_rdata_a.target;
                state_next  = S_TXT_ML;
            end

            // pop a matched pattern, if any, and refetch the stack top when text is left
            S_TXT_ML: begin
                removed_next = REMOVED_W'(m_len);
                sdepth_next  = left_depth;
                state_next   = S_DONE;
                if (m_len != '0) begin
                    if (left_depth == '0) begin
                        top_next = '0;
                    end else begin
                        ss_raddr   = SSTACK_AW'(left_depth);
                        state_next = S_TXT_TOP;
                    end
                end
            end

            S_TXT_TOP: begin
                top_next   = ss_rdata;
                state_next = S_DONE;
            end

            S_READ: begin
                rsym_next  = tx_rdata;
                state_next = S_DONE;
            end

            // build: root row
            S_B_ROOT_RD: begin
                ch_raddr_a = child_index('0, c_reg);
                state_next = S_B_ROOT_WR;
            end

            S_B_ROOT_WR: begin
                if (ch_rdata_a.valid) begin
                    fl_we     = 1'b1;
                    fl_waddr  = ch_rdata_a.target;
                    fl_wdata  = '0;
                    q_we      = 1'b1;
                    q_wdata   = ch_rdata_a.target;
                    tail_next = tail_reg + NODE_W'(1);
                end else begin
                    ch_we    = 1'b1;
                    ch_waddr = child_index('0, c_reg);
                end
                if (c_reg == SYM_W'(ALPHABET - 1)) begin
                    state_next = S_B_POP;
                end else begin
                    c_next     = c_reg + SYM_W'(1);
                    state_next = S_B_ROOT_RD;
                end
            end

            // build: take the next node off the queue
            S_B_POP: begin
                if (head_reg == tail_reg) begin
                    built_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    q_raddr    = head_reg;
                    head_next  = head_reg + NODE_W'(1);
                    state_next = S_B_FAIL;
                end
            end

            S_B_FAIL: begin
                u_next     = q_rdata;
                fl_raddr   = q_rdata;
                state_next = S_B_ROW;
            end

            S_B_ROW: begin
                f_next     = fl_rdata;
                c_next     = '0;
                state_next = S_B_RD;
            end

            // build: read own row and failure row together
            S_B_RD: begin
                ch_raddr_a = child_index(u_reg, c_reg);
                ch_raddr_b = child_index(f_reg, c_reg);
                state_next = S_B_WR;
            end

            S_B_WR: begin
                if (ch_rdata_a.valid) begin
                    fl_we     = 1'b1;
                    fl_waddr  = ch_rdata_a.target;
                    fl_wdata  = ch_rdata_b.target;
                    q_we      = 1'b1;
                    q_wdata   = ch_rdata_a.target;
                    tail_next = tail_reg + NODE_W'(1);
                end else begin
                    ch_we           = 1'b1;
                    ch_waddr        = child_index(u_reg, c_reg);
                    ch_wdata.target = ch_rdata_b.target;
                end
                if (c_reg == SYM_W'(ALPHABET - 1)) begin
                    state_next = S_B_POP;
                end else begin
                    c_next     = c_reg + SYM_W'(1);
                    state_next = S_B_RD;
                end
            end

            // hand the response to the output register
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {1'b0, rsym_reg, removed_reg, sdepth_reg, status_reg};
                    state_next  = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // checks
    `MPCF_ASSERT_IMP(a_node_bound, 1'b1, ncount_reg <= CNT_W'(MAX_NODES))
    `MPCF_ASSERT_IMP(a_text_bound, 1'b1, sdepth_reg <= DEPTH_W'(MAX_TEXT))
    `MPCF_ASSERT_NXT(a_busy_after_req, s_acc, state_reg != S_IDLE)
    `MPCF_ASSERT_IMP(a_built_from_walk, $rose(built_reg), $past(state_reg) == S_B_POP)

endmodule

/* test/multi_pattern_censoring_filter_top_tb.sv */
// scoreboard: shadow automaton plus fifo of expected responses
class censor_scoreboard;
    typedef struct {
        mpcf_pkg::status_t status;
        logic [12:0]       kept_length;
        logic [9:0]        removed_count;
        logic [4:0]        read_symbol;
    } censor_resp_t;

    localparam int EXP_D = 64;

    bit          goto_valid  [mpcf_pkg::CHILD_D];
    logic [9:0]  goto_target [mpcf_pkg::CHILD_D];
    logic [9:0]  fail_of     [mpcf_pkg::MAX_NODES];
    logic [9:0]  pat_len     [mpcf_pkg::MAX_NODES];
    logic [9:0]  parent_of   [mpcf_pkg::MAX_NODES];
    logic [9:0]  walk_fifo   [mpcf_pkg::MAX_NODES];
    logic [9:0]  state_hist  [mpcf_pkg::SSTACK_D];
    logic [4:0]  kept_text   [mpcf_pkg::MAX_TEXT];
    int          nodes_used;
    int          cursor;
    int          depth;
    bit          built;
    int          errors;
    int          censored;
    censor_resp_t exp_fifo [EXP_D];
    int          exp_wr;
    int          exp_rd;
    int          exp_count;

    function new();
        foreach (goto_valid[i]) begin
            goto_valid[i]  = 0;
            goto_target[i] = '0;
        end
        foreach (fail_of[i]) begin
            fail_of[i]   = '0;
            pat_len[i]   = '0;
            parent_of[i] = '0;
            walk_fifo[i] = '0;
        end
        foreach (state_hist[i]) state_hist[i] = '0;
        foreach (kept_text[i]) kept_text[i] = '0;
        nodes_used = 1;
        cursor     = 0;
        depth      = 0;
        built      = 0;
        errors     = 0;
        censored   = 0;
        exp_wr     = 0;
        exp_rd     = 0;
        exp_count  = 0;
    endfunction

    function int fold_letter(logic [4:0] s);
        return (int'(s) >= mpcf_pkg::ALPHABET) ? mpcf_pkg::ALPHABET - 1 : int'(s);
    endfunction

    function int trie_depth(int n);
        int d;
        int guard;
        d = 0;
        guard = 0;
        while (n != 0 && n < mpcf_pkg::MAX_NODES && guard < mpcf_pkg::MAX_NODES) begin
            n = int'(parent_of[n]);
            d++;
            guard++;
        end
        return d;
    endfunction

    // breadth-first failure links and goto completion
    function void build_links();
        int head;
        int tail;
        int u;
        int f;
        int ui;
        int fi;
        int v;
        head = 0;
        tail = 0;
        for (int c = 0; c < mpcf_pkg::ALPHABET; c++) begin
            if (goto_valid[c]) begin
                v = int'(goto_target[c]);
                fail_of[v] = '0;
                if (tail < mpcf_pkg::MAX_NODES) walk_fifo[tail++] = 10'(v);
            end else begin
                goto_target[c] = '0;
            end
        end
        while (head < tail) begin
            u = int'(walk_fifo[head++]);
            f = int'(fail_of[u]);
            for (int c = 0; c < mpcf_pkg::ALPHABET; c++) begin
                ui = u * mpcf_pkg::ALPHABET + c;
                fi = f * mpcf_pkg::ALPHABET + c;
                if (goto_valid[ui]) begin
                    v = int'(goto_target[ui]);
                    fail_of[v] = goto_target[fi];
                    if (tail < mpcf_pkg::MAX_NODES) walk_fifo[tail++] = 10'(v);
                end else begin
                    goto_target[ui] = goto_target[fi];
                end
            end
        end
        built = 1;
    endfunction

    // predict the response of one accepted request
    function void note_request(mpcf_pkg::op_t op, logic [4:0] sym, logic last,
                               logic [11:0] pos);
        censor_resp_t r;
        int s;
        int idx;
        int cur;
        int nxt;
        int m;
        bit ok;
        r.status = mpcf_pkg::ST_OK;
        r.removed_count = '0;
        r.read_symbol = '0;
        case (op)
            mpcf_pkg::OP_PATTERN: begin
                if (built) begin
                    r.status = mpcf_pkg::ST_WRONG;
                end else begin
                    s = fold_letter(sym);
                    idx = cursor * mpcf_pkg::ALPHABET + s;
                    ok = 1;
                    if (!goto_valid[idx]) begin
                        if (nodes_used >= mpcf_pkg::MAX_NODES) begin
                            ok = 0;
                            r.status = mpcf_pkg::ST_NODE_FULL;
                        end else begin
                            goto_valid[idx] = 1;
                            goto_target[idx] = 10'(nodes_used);
                            parent_of[nodes_used] = 10'(cursor);
                            fail_of[nodes_used] = '0;
                            pat_len[nodes_used] = '0;
                            nodes_used++;
                        end
                    end
                    if (ok) begin
                        cursor = int'(goto_target[idx]);
                        if (last) pat_len[cursor] = 10'(trie_depth(cursor));
                    end
                    if (last) cursor = 0;
                end
            end
            mpcf_pkg::OP_BUILD: begin
                if (built) r.status = mpcf_pkg::ST_WRONG;
                else build_links();
            end
            mpcf_pkg::OP_TEXT: begin
                if (!built) begin
                    r.status = mpcf_pkg::ST_WRONG;
                end else if (depth >= mpcf_pkg::MAX_TEXT) begin
                    r.status = mpcf_pkg::ST_TEXT_FULL;
                end else begin
                    s = fold_letter(sym);
                    cur = int'(state_hist[depth]);
                    nxt = int'(goto_target[cur * mpcf_pkg::ALPHABET + s]);
                    kept_text[depth] = 5'(s);
                    depth++;
                    state_hist[depth] = 10'(nxt);
                    m = int'(pat_len[nxt]);
                    if (m > depth) m = depth;
                    depth -= m;
                    r.removed_count = 10'(m);
                    if (m != 0) censored++;
                end
            end
            default: begin
                if (int'(pos) >= depth) r.status = mpcf_pkg::ST_POS_BEYOND;
                else r.read_symbol = kept_text[pos];
            end
        endcase
        r.kept_length = 13'(depth);
        exp_fifo[exp_wr] = r;
        exp_wr = (exp_wr + 1) % EXP_D;
        exp_count++;
    endfunction

    // compare one response against the oldest prediction
    function void check_response(logic [31:0] d);
        censor_resp_t e;
        if (exp_count == 0) begin
            $error("response with nothing expected: %h", d);
            errors++;
            return;
        end
        e = exp_fifo[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_D;
        exp_count--;
        if (d[2:0] !== e.status) begin
            $error("status expected %0d actual %0d", e.status, d[2:0]);
            errors++;
        end
        if (d[15:3] !== e.kept_length) begin
            $error("kept_length expected %0d actual %0d", e.kept_length, d[15:3]);
            errors++;
        end
        if (d[25:16] !== e.removed_count) begin
            $error("removed_count expected %0d actual %0d", e.removed_count, d[25:16]);
            errors++;
        end
        if (d[30:26] !== e.read_symbol) begin
            $error("read_symbol expected %0d actual %0d", e.read_symbol, d[30:26]);
            errors++;
        end
    endfunction
endclass

module multi_pattern_censoring_filter_top_tb;
    import mpcf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 300000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    censor_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    bit  hold_started;
    bit  long_hold_req;
    int  quiet_cycles;
    int  sent_total;

    multi_pattern_censoring_filter_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // offer one request and wait until it is taken
    task automatic send_request(op_t op, logic [4:0] sym, logic last, logic [11:0] pos);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {7'd0, pos, sym};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, sym, last, pos);
        sent_total++;
    endtask

    // wait until every response is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.exp_count != 0) @(posedge aclk);
    endtask

    // receiver ready with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            hold_cycles  <= 0;
            hold_started <= 1'b0;
        end else if (long_hold_req && !hold_started) begin
            m_tready     <= 1'b0;
            hold_cycles  <= 400;
            hold_started <= 1'b1;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // response check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_response(m_tdata);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [4:0] sym;
        int pick;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = OP_PATTERN;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b0;
        sent_total = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // wrong phase and empty reads before the build
        send_idle_pct = 27;
        recv_idle_pct = 79;
        send_request(OP_READ, 5'd0, 1'b0, 12'd0);
        send_request(OP_READ, 5'd31, 1'b1, 12'hFFF);
        send_request(OP_TEXT, 5'd1, 1'b0, 12'd0);
        // fixed patterns: ab, bc, abcd, a clamped letter alone
        send_request(OP_PATTERN, 5'd0, 1'b0, 12'd0);
        send_request(OP_PATTERN, 5'd1, 1'b1, 12'd0);
        send_request(OP_PATTERN, 5'd1, 1'b0, 12'd0);
        send_request(OP_PATTERN, 5'd2, 1'b1, 12'd0);
        send_request(OP_PATTERN, 5'd0, 1'b0, 12'd0);
        send_request(OP_PATTERN, 5'd1, 1'b0, 12'd0);
        send_request(OP_PATTERN, 5'd2, 1'b0, 12'd0);
        send_request(OP_PATTERN, 5'd3, 1'b1, 12'd0);
        send_request(OP_PATTERN, 5'd30, 1'b1, 12'd0);

        // a dozen random short patterns over a few letters
        for (int p = 0; p < 12; p++) begin
            pick = $urandom_range(4, 1);
            for (int k = 0; k < pick; k++)
                send_request(OP_PATTERN, 5'($urandom_range(4)), 1'(k == pick - 1),
                             12'($urandom));
        end

        // build, then repeated build and late pattern
        send_request(OP_BUILD, 5'd0, 1'b0, 12'd0);
        send_request(OP_BUILD, 5'd0, 1'b0, 12'd0);
        send_request(OP_PATTERN, 5'd0, 1'b1, 12'd0);
        send_request(OP_TEXT, 5'd31, 1'b0, 12'd0);
        send_request(OP_READ, 5'd0, 1'b0, 12'd0);

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 27 : 0;
            if (phase == 2) long_hold_req <= 1'b1;
            for (int n = 0; n < 298; n++) begin
                pick = $urandom_range(99);
                if (pick < 78) begin
                    sym = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(5));
                    send_request(OP_TEXT, sym, 1'($urandom), 12'($urandom));
                end else if (pick < 92) begin
                    send_request(OP_READ, 5'($urandom), 1'($urandom),
                                 ($urandom_range(3) == 0) ? 12'($urandom)
                                 : 12'($urandom_range(sb.depth + 1)));
                end else if (pick < 96) begin
                    send_request(OP_PATTERN, 5'($urandom), 1'($urandom), 12'($urandom));
                end else begin
                    send_request(OP_BUILD, 5'($urandom), 1'($urandom), 12'($urandom));
                end
            end
            drain();
        end

        // reads at the far end, at the start and at random places
        send_request(OP_READ, 5'd0, 1'b0, 12'hFFF);
        send_request(OP_READ, 5'd0, 1'b0, 12'd0);
        for (int k = 0; k < 8; k++) send_request(OP_READ, 5'd0, 1'b0, 12'($urandom));
        drain();
        repeat (60) @(posedge aclk);

        $display("covered %0d requests: trie inserts, one build, %0d censored matches",
                 sent_total, sb.censored);
        $display("wrong-phase requests, a long receiver hold-off, reads in and past the text");
        if (sb.errors == 0 && sb.exp_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
